@@ hw/rtl/mccd_pkg.sv @@
// Shared constants and codes of the motion command change dispatcher.
`default_nettype none

package mccd_pkg;

    // Default width of the position setpoints
    localparam int POS_WIDTH_DEFAULT = 16;

    // Width of speed and setpoint fields in the drive messages
    localparam int MSG_WIDTH = 16;

    // Packed flag layout
    localparam int FLAG_WIDTH = 6;
    localparam int EV_WIDTH   = 7;
    localparam int BIT_EN     = 2;
    localparam int BIT_DIR    = 3;
    localparam int BIT_AXIS   = 4;
    localparam int BIT_LIFT   = 5;
    localparam int BIT_POSCHG = 6;

    // Panel mode codes
    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_FREE = 2'd1;
    localparam logic [1:0] MODE_AUTO = 2'd2;
    localparam logic [1:0] MODE_LIFT = 2'd3;

    // Mode change patterns (old mode XOR new mode)
    localparam logic [1:0] MODE_EV_LO   = 2'd1;
    localparam logic [1:0] MODE_EV_HI   = 2'd2;
    localparam logic [1:0] MODE_EV_BOTH = 2'd3;

    // Drive commands
    localparam logic [1:0] CMD_STOP = 2'd0;
    localparam logic [1:0] CMD_FREE = 2'd1;
    localparam logic [1:0] CMD_LOOP = 2'd2;

    // Lift commands
    localparam logic [1:0] LIFT_STOP = 2'd0;
    localparam logic [1:0] LIFT_UP   = 2'd1;
    localparam logic [1:0] LIFT_DOWN = 2'd2;

    // Main power actions
    localparam logic [1:0] PWR_NONE = 2'd0;
    localparam logic [1:0] PWR_OFF  = 2'd1;
    localparam logic [1:0] PWR_ON   = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/motion_command_change_dispatcher.sv @@
// Motion command change dispatcher: panel snapshot in, drive commands out.
// The result register is the only stage; it holds a word's result from the
//   cycle after the word is accepted. One word per cycle while out_ready is
//   high: in_ready = !out_valid || out_ready lets a word in as one is taken.
// Reset (rst_n low, asynchronous): previous flags and setpoints clear to zero,
//   out_valid clears; result payload registers are not reset.
`default_nettype none

module motion_command_change_dispatcher #(
    parameter int POS_WIDTH = mccd_pkg::POS_WIDTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     mode,
    input  wire logic                           control_enable,
    input  wire logic                           run_direction,
    input  wire logic                           run_axis,
    input  wire logic                           lift_direction,
    input  wire logic [POS_WIDTH-1:0]           arm_position,
    input  wire logic [POS_WIDTH-1:0]           pole_position,
    input  wire logic [mccd_pkg::MSG_WIDTH-1:0] arm_velocity,
    input  wire logic [mccd_pkg::MSG_WIDTH-1:0] pole_velocity,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                arm_send,
    output logic [1:0]                          arm_command,
    output logic                                pole_send,
    output logic [1:0]                          pole_command,
    output logic                                lift_send,
    output logic [1:0]                          lift_command,
    output logic                                drive_direction,
    output logic [mccd_pkg::MSG_WIDTH-1:0]      arm_speed,
    output logic [mccd_pkg::MSG_WIDTH-1:0]      arm_setpoint,
    output logic [mccd_pkg::MSG_WIDTH-1:0]      pole_speed,
    output logic [mccd_pkg::MSG_WIDTH-1:0]      pole_setpoint,
    output logic [1:0]                          power_action
);
    import mccd_pkg::*;

    // ------------------------------------------------------------------
    // State carried from the previous accepted word
    // ------------------------------------------------------------------
    logic [FLAG_WIDTH-1:0] last_flags_reg;
    logic [POS_WIDTH-1:0]  last_arm_pos_reg;
    logic [POS_WIDTH-1:0]  last_pole_pos_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  arm_send_reg;
    logic [1:0]            arm_cmd_reg;
    logic                  pole_send_reg;
    logic [1:0]            pole_cmd_reg;
    logic                  lift_send_reg;
    logic [1:0]            lift_cmd_reg;
    logic                  dir_reg;
    logic [MSG_WIDTH-1:0]  arm_speed_reg;
    logic [MSG_WIDTH-1:0]  arm_sp_reg;
    logic [MSG_WIDTH-1:0]  pole_speed_reg;
    logic [MSG_WIDTH-1:0]  pole_sp_reg;
    logic [1:0]            power_reg;

    logic                  in_accept;
    logic [FLAG_WIDTH-1:0] flags;
    logic [EV_WIDTH-1:0]   ev;
    logic [1:0]            mode_ev;
    logic                  dispatch;

    logic                  s_arm;
    logic                  s_pole;
    logic                  s_lift;
    logic                  t_stop;
    logic                  t_free;
    logic                  t_loop;
    logic                  t_up;
    logic [1:0]            power;
    logic [1:0]            dcmd;
    logic [1:0]            lcmd;

    // Setpoints narrowed or widened to the message field width
    logic [MSG_WIDTH-1:0]  arm_pos_msg;
    logic [MSG_WIDTH-1:0]  pole_pos_msg;

    // Next values of the result register
    logic                  arm_send_next;
    logic [1:0]            arm_cmd_next;
    logic                  pole_send_next;
    logic [1:0]            pole_cmd_next;
    logic                  lift_send_next;
    logic [1:0]            lift_cmd_next;
    logic                  dir_next;
    logic [MSG_WIDTH-1:0]  arm_speed_next;
    logic [MSG_WIDTH-1:0]  arm_sp_next;
    logic [MSG_WIDTH-1:0]  pole_speed_next;
    logic [MSG_WIDTH-1:0]  pole_sp_next;
    logic [1:0]            power_next;

    // The result register frees up in the same cycle it is taken
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    generate
        if (POS_WIDTH >= MSG_WIDTH) begin : g_pos_trunc
            assign arm_pos_msg  = arm_position[MSG_WIDTH-1:0];
            assign pole_pos_msg = pole_position[MSG_WIDTH-1:0];
        end else begin : g_pos_ext
            assign arm_pos_msg  = {{(MSG_WIDTH-POS_WIDTH){1'b0}}, arm_position};
            assign pole_pos_msg = {{(MSG_WIDTH-POS_WIDTH){1'b0}}, pole_position};
        end
    endgenerate

    // ------------------------------------------------------------------
    // Change detection: pack flags, XOR with last, fold in setpoint change
    // ------------------------------------------------------------------
    assign flags = {lift_direction, run_axis, run_direction, control_enable, mode};

    always_comb
    begin
        ev[FLAG_WIDTH-1:0] = flags ^ last_flags_reg;
        ev[BIT_POSCHG]     = (arm_position != last_arm_pos_reg)
                          || (pole_position != last_pole_pos_reg);
    end

    assign mode_ev  = ev[1:0];
    // Runs when anything changed and control is on now or was on before
    assign dispatch = (ev != '0) && (control_enable || last_flags_reg[BIT_EN]);

    // ------------------------------------------------------------------
    // Dispatch decode
    // ------------------------------------------------------------------
    always_comb
    begin
        s_arm  = 1'b0;
        s_pole = 1'b0;
        s_lift = 1'b0;
        t_stop = 1'b0;
        t_free = 1'b0;
        t_loop = 1'b0;
        t_up   = 1'b0;
        power  = PWR_NONE;

        case (mode)
            MODE_STOP:
            begin
                // Leaving free run, or axis switched: stop the selected drive
                if (mode_ev == MODE_EV_LO || ev[BIT_AXIS]) begin
                    t_stop = 1'b1;
                    s_pole = run_axis;
                    s_arm  = !run_axis;
                end else if (mode_ev == MODE_EV_HI) begin
                    // Leaving closed loop: stop both drives
                    t_stop = 1'b1;
                    s_arm  = 1'b1;
                    s_pole = 1'b1;
                end else if (mode_ev == MODE_EV_BOTH) begin
                    // Leaving lift mode: stop the lift
                    t_stop = 1'b1;
                    s_lift = 1'b1;
                end
            end
            MODE_FREE:
            begin
                t_free = 1'b1;
                s_pole = run_axis;
                s_arm  = !run_axis;
            end
            MODE_AUTO:
            begin
                t_loop = 1'b1;
                s_arm  = 1'b1;
                s_pole = 1'b1;
            end
            default:
            begin
                s_lift = 1'b1;
                t_up   = lift_direction;
            end
        endcase

        // Enable edge: disable stops everything and cuts power; enable powers on
        if (ev[BIT_EN]) begin
            if (!control_enable) begin
                t_stop = 1'b1;
                s_arm  = 1'b1;
                s_pole = 1'b1;
                s_lift = 1'b1;
                power  = PWR_OFF;
            end else begin
                power  = PWR_ON;
            end
        end
    end

    always_comb
    begin
        if (t_stop) begin
            dcmd = CMD_STOP;
        end else if (t_free) begin
            dcmd = CMD_FREE;
        end else if (t_loop) begin
            dcmd = CMD_LOOP;
        end else begin
            dcmd = CMD_STOP;
        end

        if (t_stop) begin
            lcmd = LIFT_STOP;
        end else if (t_up) begin
            lcmd = LIFT_UP;
        end else begin
            lcmd = LIFT_DOWN;
        end
    end

    // Unsent fields read zero; no dispatch means an all-zero word
    always_comb
    begin
        arm_send_next   = dispatch && s_arm;
        pole_send_next  = dispatch && s_pole;
        lift_send_next  = dispatch && s_lift;
        arm_cmd_next    = arm_send_next  ? dcmd          : CMD_STOP;
        arm_speed_next  = arm_send_next  ? arm_velocity  : '0;
        arm_sp_next     = arm_send_next  ? arm_pos_msg   : '0;
        pole_cmd_next   = pole_send_next ? dcmd          : CMD_STOP;
        pole_speed_next = pole_send_next ? pole_velocity : '0;
        pole_sp_next    = pole_send_next ? pole_pos_msg  : '0;
        lift_cmd_next   = lift_send_next ? lcmd          : LIFT_STOP;
        dir_next        = (arm_send_next || pole_send_next) && run_direction;
        power_next      = dispatch ? power : PWR_NONE;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_flags_reg    <= '0;
            last_arm_pos_reg  <= '0;
            last_pole_pos_reg <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (in_accept) begin
                last_flags_reg    <= flags;
                last_arm_pos_reg  <= arm_position;
                last_pole_pos_reg <= pole_position;
                out_valid_reg     <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            arm_send_reg   <= arm_send_next;
            arm_cmd_reg    <= arm_cmd_next;
            pole_send_reg  <= pole_send_next;
            pole_cmd_reg   <= pole_cmd_next;
            lift_send_reg  <= lift_send_next;
            lift_cmd_reg   <= lift_cmd_next;
            dir_reg        <= dir_next;
            arm_speed_reg  <= arm_speed_next;
            arm_sp_reg     <= arm_sp_next;
            pole_speed_reg <= pole_speed_next;
            pole_sp_reg    <= pole_sp_next;
            power_reg      <= power_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign arm_send        = arm_send_reg;
    assign arm_command     = arm_cmd_reg;
    assign pole_send       = pole_send_reg;
    assign pole_command    = pole_cmd_reg;
    assign lift_send       = lift_send_reg;
    assign lift_command    = lift_cmd_reg;
    assign drive_direction = dir_reg;
    assign arm_speed       = arm_speed_reg;
    assign arm_setpoint    = arm_sp_reg;
    assign pole_speed      = pole_speed_reg;
    assign pole_setpoint   = pole_sp_reg;
    assign power_action    = power_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An accepted word always shows up as a result in the next cycle
    a_accept_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted word did not produce a result");

    // Power off comes only with stop sent to all three drives
    a_power_off_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && power_reg == PWR_OFF) |->
        (arm_send_reg && pole_send_reg && lift_send_reg
         && arm_cmd_reg == CMD_STOP && pole_cmd_reg == CMD_STOP
         && lift_cmd_reg == LIFT_STOP))
        else $error("power off without full stop");

    // Direction is only carried in an arm or pole message
    a_dir_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dir_reg) |-> (arm_send_reg || pole_send_reg))
        else $error("drive direction set without drive message");

    // Arm and pole always receive the same drive command when both are sent
    a_same_drive_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && arm_send_reg && pole_send_reg) |->
        (arm_cmd_reg == pole_cmd_reg))
        else $error("arm and pole commands differ");

    // Previous flags follow the accepted word
    a_flags_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (last_flags_reg == $past(flags)))
        else $error("previous flags not updated");

endmodule

`default_nettype wire

@@ tb/mccd_checker.sv @@
// Watches both channels of the dispatcher, predicts each result word and compares it.
`default_nettype none

module mccd_checker
    import mccd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [1:0]            mode,
    input  wire logic                  control_enable,
    input  wire logic                  run_direction,
    input  wire logic                  run_axis,
    input  wire logic                  lift_direction,
    input  wire logic [MSG_WIDTH-1:0]  arm_position,
    input  wire logic [MSG_WIDTH-1:0]  pole_position,
    input  wire logic [MSG_WIDTH-1:0]  arm_velocity,
    input  wire logic [MSG_WIDTH-1:0]  pole_velocity,

    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic                  arm_send,
    input  wire logic [1:0]            arm_command,
    input  wire logic                  pole_send,
    input  wire logic [1:0]            pole_command,
    input  wire logic                  lift_send,
    input  wire logic [1:0]            lift_command,
    input  wire logic                  drive_direction,
    input  wire logic [MSG_WIDTH-1:0]  arm_speed,
    input  wire logic [MSG_WIDTH-1:0]  arm_setpoint,
    input  wire logic [MSG_WIDTH-1:0]  pole_speed,
    input  wire logic [MSG_WIDTH-1:0]  pole_setpoint,
    input  wire logic [1:0]            power_action,

    output int                         mismatches,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]           mode;
        logic                 en;
        logic                 dir;
        logic                 axis;
        logic                 lift;
        logic [MSG_WIDTH-1:0] arm_pos;
        logic [MSG_WIDTH-1:0] pole_pos;
        logic [MSG_WIDTH-1:0] arm_vel;
        logic [MSG_WIDTH-1:0] pole_vel;
    } panel_t;

    typedef struct packed {
        logic                 arm_send;
        logic [1:0]           arm_cmd;
        logic                 pole_send;
        logic [1:0]           pole_cmd;
        logic                 lift_send;
        logic [1:0]           lift_cmd;
        logic                 dir;
        logic [MSG_WIDTH-1:0] arm_speed;
        logic [MSG_WIDTH-1:0] arm_setpoint;
        logic [MSG_WIDTH-1:0] pole_speed;
        logic [MSG_WIDTH-1:0] pole_setpoint;
        logic [1:0]           power;
    } commands_t;

    logic [FLAG_WIDTH-1:0] prev_flags;
    logic [MSG_WIDTH-1:0]  prev_arm_pos;
    logic [MSG_WIDTH-1:0]  prev_pole_pos;
    commands_t             due_commands[$];

    // Drive, lift and power commands for one panel word against the previous one.
    function automatic commands_t drive_commands(panel_t p);
        logic [FLAG_WIDTH-1:0] flags;
        logic [EV_WIDTH-1:0]   ev;
        logic [1:0]            mode_ev;
        logic [1:0]            drive_cmd;
        logic [1:0]            lift_cmd;
        logic                  to_arm;
        logic                  to_pole;
        logic                  to_lift;
        logic                  want_stop;
        logic                  want_free;
        logic                  want_loop;
        logic                  want_up;
        commands_t             c;

        flags = {p.lift, p.axis, p.dir, p.en, p.mode};
        ev = {1'b0, flags ^ prev_flags};
        if (p.arm_pos != prev_arm_pos || p.pole_pos != prev_pole_pos)
            ev[BIT_POSCHG] = 1'b1;
        mode_ev = ev[1:0];
        c = '0;
        to_arm = 1'b0;
        to_pole = 1'b0;
        to_lift = 1'b0;
        want_stop = 1'b0;
        want_free = 1'b0;
        want_loop = 1'b0;
        want_up = 1'b0;

        if (ev != '0 && (p.en || prev_flags[BIT_EN]))
        begin
            case (p.mode)
                MODE_STOP:
                begin
                    // stop follows the axis the panel selects now
                    if (mode_ev == MODE_EV_LO || ev[BIT_AXIS])
                    begin
                        want_stop = 1'b1;
                        to_pole = p.axis;
                        to_arm = !p.axis;
                    end
                    else if (mode_ev == MODE_EV_HI)
                    begin
                        want_stop = 1'b1;
                        to_arm = 1'b1;
                        to_pole = 1'b1;
                    end
                    else if (mode_ev == MODE_EV_BOTH)
                    begin
                        want_stop = 1'b1;
                        to_lift = 1'b1;
                    end
                end
                MODE_FREE:
                begin
                    want_free = 1'b1;
                    to_pole = p.axis;
                    to_arm = !p.axis;
                end
                MODE_AUTO:
                begin
                    want_loop = 1'b1;
                    to_arm = 1'b1;
                    to_pole = 1'b1;
                end
                default:
                begin
                    to_lift = 1'b1;
                    want_up = p.lift;
                end
            endcase

            if (ev[BIT_EN])
            begin
                if (!p.en)
                begin
                    want_stop = 1'b1;
                    to_arm = 1'b1;
                    to_pole = 1'b1;
                    to_lift = 1'b1;
                    c.power = PWR_OFF;
                end
                else
                begin
                    c.power = PWR_ON;
                end
            end

            drive_cmd = want_stop ? CMD_STOP :
                        want_free ? CMD_FREE :
                        want_loop ? CMD_LOOP : CMD_STOP;
            lift_cmd = want_stop ? LIFT_STOP : (want_up ? LIFT_UP : LIFT_DOWN);
            if (to_arm)
            begin
                c.arm_send = 1'b1;
                c.arm_cmd = drive_cmd;
                c.arm_speed = p.arm_vel;
                c.arm_setpoint = p.arm_pos;
            end
            if (to_pole)
            begin
                c.pole_send = 1'b1;
                c.pole_cmd = drive_cmd;
                c.pole_speed = p.pole_vel;
                c.pole_setpoint = p.pole_pos;
            end
            if (to_lift)
            begin
                c.lift_send = 1'b1;
                c.lift_cmd = lift_cmd;
            end
            if (to_arm || to_pole)
                c.dir = p.dir;
        end
        return c;
    endfunction

    function automatic string describe(commands_t c);
        return $sformatf("arm %0b/%0d pole %0b/%0d lift %0b/%0d dir %0b arm %h/%h pole %h/%h pwr %0d",
                         c.arm_send, c.arm_cmd, c.pole_send, c.pole_cmd, c.lift_send,
                         c.lift_cmd, c.dir, c.arm_speed, c.arm_setpoint, c.pole_speed,
                         c.pole_setpoint, c.power);
    endfunction

    always @(posedge clk)
    begin
        panel_t    word_in;
        commands_t want;
        commands_t got;

        if (!rst_n)
        begin
            prev_flags = '0;
            prev_arm_pos = '0;
            prev_pole_pos = '0;
            due_commands.delete();
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            // retire first so a stray result never matches a word entering now
            if (out_valid && out_ready)
            begin
                got = {arm_send, arm_command, pole_send, pole_command, lift_send,
                       lift_command, drive_direction, arm_speed, arm_setpoint,
                       pole_speed, pole_setpoint, power_action};
                if (due_commands.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result word with nothing expected: %s",
                                 $time, describe(got));
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = due_commands.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: result word mismatch", $time);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(got));
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                word_in = {mode, control_enable, run_direction, run_axis, lift_direction,
                           arm_position, pole_position, arm_velocity, pole_velocity};
                due_commands.push_back(drive_commands(word_in));
                prev_flags = {word_in.lift, word_in.axis, word_in.dir, word_in.en,
                              word_in.mode};
                prev_arm_pos = word_in.arm_pos;
                prev_pole_pos = word_in.pole_pos;
            end

            pending <= due_commands.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_motion_command_change_dispatcher.sv @@
// Top of the dispatcher testbench: clock, reset, panel words, result back-pressure, verdict.
`default_nettype none

module tb_motion_command_change_dispatcher;
    timeunit 1ns;
    timeprecision 1ps;

    import mccd_pkg::*;

    localparam int RANDOM_WORDS = 1200;
    localparam int QUIET_WORDS  = 150;     // tail of the run with no idling
    localparam int HOLD_AT      = 300;     // random word that starts the long receiver hold
    localparam int DRAIN_AT     = 700;     // random word before which the sender drains
    localparam int LONG_HOLD    = 250;     // cycles the receiver holds off
    localparam int LIMIT_CYCLES = 200000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           mode = '0;
    logic                 control_enable = 1'b0;
    logic                 run_direction = 1'b0;
    logic                 run_axis = 1'b0;
    logic                 lift_direction = 1'b0;
    logic [MSG_WIDTH-1:0] arm_position = '0;
    logic [MSG_WIDTH-1:0] pole_position = '0;
    logic [MSG_WIDTH-1:0] arm_velocity = '0;
    logic [MSG_WIDTH-1:0] pole_velocity = '0;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 arm_send;
    logic [1:0]           arm_command;
    logic                 pole_send;
    logic [1:0]           pole_command;
    logic                 lift_send;
    logic [1:0]           lift_command;
    logic                 drive_direction;
    logic [MSG_WIDTH-1:0] arm_speed;
    logic [MSG_WIDTH-1:0] arm_setpoint;
    logic [MSG_WIDTH-1:0] pole_speed;
    logic [MSG_WIDTH-1:0] pole_setpoint;
    logic [1:0]           power_action;

    int                   mismatches;
    int                   pending;      // result words still owed by the block

    logic                 quiet = 1'b0;     // set for the tail: no idling on either side
    logic                 hold_req = 1'b0;  // asks the receiver for one long hold-off

    always #6 clk = ~clk;

    motion_command_change_dispatcher dut (.*);

    mccd_checker cmd_check (.*);

    // Offer one panel word and return at the edge that takes it. A random gap
    // may come first; valid is never dropped once it is up.
    task automatic send_word(input logic [1:0] m, input logic en, input logic dir,
                             input logic axis, input logic lift,
                             input logic [MSG_WIDTH-1:0] apos,
                             input logic [MSG_WIDTH-1:0] ppos,
                             input logic [MSG_WIDTH-1:0] avel,
                             input logic [MSG_WIDTH-1:0] pvel);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        control_enable <= en;
        run_direction <= dir;
        run_axis <= axis;
        lift_direction <= lift;
        arm_position <= apos;
        pole_position <= ppos;
        arm_velocity <= avel;
        pole_velocity <= pvel;
        do @(posedge clk); while (!in_ready);
    endtask

    // Picks a 16-bit value, leaning on the ends of the range.
    function automatic logic [MSG_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return MSG_WIDTH'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        logic [1:0]           m;
        logic                 en;
        logic                 dir;
        logic                 axis;
        logic                 lift;
        logic [MSG_WIDTH-1:0] apos;
        logic [MSG_WIDTH-1:0] ppos;
        logic [MSG_WIDTH-1:0] avel;
        logic [MSG_WIDTH-1:0] pvel;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through the panel states. Flags start from zero after
        // reset, so the first word changes nothing and dispatches nothing.
        send_word(MODE_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // enable in stop mode: power on, no drive message
        send_word(MODE_STOP, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // free run on the arm, full speed
        send_word(MODE_FREE, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        // axis flips to the pole while free running
        send_word(MODE_FREE, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h1234, 16'hFFFF);
        // leaving free run: stop goes to the pole only
        send_word(MODE_STOP, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h1234, 16'hFFFF);
        // axis change while stopped: stop to the arm
        send_word(MODE_STOP, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001);
        // direction change only: dispatch runs but sends nothing
        send_word(MODE_STOP, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001);
        // closed loop on both drives at the top setpoints
        send_word(MODE_AUTO, 1'b1, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
        // setpoint changes alone retrigger closed loop
        send_word(MODE_AUTO, 1'b1, 1'b0, 1'b0, 1'b0, 16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF);
        send_word(MODE_AUTO, 1'b1, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h0001, 16'h0000, 16'hFFFF);
        // leaving closed loop: stop to both drives
        send_word(MODE_STOP, 1'b1, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h0001, 16'h0000, 16'hFFFF);
        // lift up, lift down, then stop mode stops the lift
        send_word(MODE_LIFT, 1'b1, 1'b0, 1'b0, 1'b1, 16'h8000, 16'h0001, 16'h0000, 16'hFFFF);
        send_word(MODE_LIFT, 1'b1, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h0001, 16'h0000, 16'hFFFF);
        send_word(MODE_STOP, 1'b1, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h0001, 16'h0000, 16'hFFFF);
        // disable on entering lift mode: stop to all three, power off
        send_word(MODE_LIFT, 1'b0, 1'b1, 1'b0, 1'b1, 16'h8000, 16'h0001, 16'hAAAA, 16'h5555);
        // still disabled: changes are ignored
        send_word(MODE_LIFT, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555);
        // enable straight into free run on the pole: power on with the start
        send_word(MODE_FREE, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA);
        // only speeds change: no event, nothing sent
        send_word(MODE_FREE, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000);
        // disable overrides a closed-loop start
        send_word(MODE_AUTO, 1'b0, 1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_word(MODE_AUTO, 1'b1, 1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_word(MODE_AUTO, 1'b1, 1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // disable out of closed loop together with an axis change
        send_word(MODE_STOP, 1'b0, 1'b0, 1'b1, 1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);

        // Random panel words. Control is mostly enabled so the dispatch runs;
        // setpoints are often held so flag changes stand alone, and some words
        // repeat the previous one exactly.
        m = MODE_STOP;
        en = 1'b0;
        dir = 1'b0;
        axis = 1'b1;
        lift = 1'b0;
        apos = 16'hFFFF;
        ppos = 16'h0000;
        avel = '0;
        pvel = '0;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            quiet = (i >= RANDOM_WORDS - QUIET_WORDS);
            if (i == HOLD_AT)
                hold_req = 1'b1;
            if (i == DRAIN_AT)
            begin
                // sender pause until the block owes nothing
                in_valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
            if ($urandom_range(0, 9) != 0)
            begin
                m = 2'($urandom_range(0, 3));
                en = ($urandom_range(0, 9) != 0);
                dir = 1'($urandom);
                axis = 1'($urandom);
                lift = 1'($urandom);
                if ($urandom_range(0, 1) == 0)
                    apos = pick_value();
                if ($urandom_range(0, 1) == 0)
                    ppos = pick_value();
                avel = pick_value();
                pvel = pick_value();
            end
            send_word(m, en, dir, axis, lift, apos, ppos, avel, pvel);
        end

        // drain, then idle to catch any stray result word
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: ready in random stretches, with stalls of random length between them,
    // one long hold-off on request so the block backs up into its input.
    initial
    begin : receiver
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Run limit, far above the slowest legal run.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
